// ===== hw/rtl/bru_pkg.sv =====
// Shared types and constants for the bitmap row unpacker.
package bru_pkg;

    // Source pixel formats (format register codes)
    localparam logic [1:0] FMT_PAL8   = 2'd0;
    localparam logic [1:0] FMT_RGB555 = 2'd1;
    localparam logic [1:0] FMT_BGR24  = 2'd2;
    localparam logic [1:0] FMT_ARGB32 = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_FORMAT    = 2'd0;
    localparam logic [1:0] REG_ROW_WIDTH = 2'd1;
    localparam logic [1:0] REG_ROW_COUNT = 2'd2;

    // Input word commands
    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_DATA    = 1'b1;

    // Rows per frame never exceed this
    localparam logic [12:0] MAX_ROWS = 13'd4096;

    // 5-5-5 channel masks
    localparam logic [15:0] MASK_RED   = 16'h7C00;
    localparam logic [15:0] MASK_GREEN = 16'h03E0;
    localparam logic [15:0] MASK_BLUE  = 16'h001F;

    // Decoded pixel handed from the unpacker to the output pipeline
    typedef struct packed {
        logic        valid;
        logic        palette;
        logic [31:0] pixel;
        logic        row_end;
        logic        frame_end;
    } pix_info_t;

endpackage

// ===== hw/rtl/bitmap_row_to_argb32_unpacker_unit.sv =====
// Top level: bitmap row byte stream to 32-bit pixel words.
// A pixel word passes through the stage 1 register and then the output register after its last source byte is accepted.
// Throughput: one byte word per cycle; the palette read and the output register
// form a two-register pipeline, and the input stalls only when both are full.
// Reset (rst_n, async low): format 32 bpp, width and rows one, stream counters
// cleared, palette reads as zero until written (per-entry valid bits, no sweep).
module bitmap_row_to_argb32_unpacker_unit #(
    parameter int MAX_ROW_PIXELS = 4096,
    parameter int PALETTE_DEPTH  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  palette_index,
    input  logic [7:0]  palette_red,
    input  logic [7:0]  palette_green,
    input  logic [7:0]  palette_blue,
    input  logic [7:0]  source_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_word,
    output logic        row_end,
    output logic        frame_end,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    bru_pkg::pix_info_t info;
    bru_pkg::pix_info_t s1_info_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [31:0]        pixel_reg;
    logic               row_end_reg;
    logic               frame_end_reg;
    logic               take;
    logic               out_load;
    logic [23:0]        pal_color;

    // Pipeline handshake
    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || out_load;
    assign take     = in_valid && in_ready;

    bru_unpack #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_unpack (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .command     (command),
        .source_byte (source_byte),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .info        (info)
    );

    bru_palette #(
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (take && (command == bru_pkg::CMD_PALETTE)),
        .wr_index (palette_index),
        .wr_color ({palette_red, palette_green, palette_blue}),
        .rd_en    (take),
        .rd_index (source_byte),
        .rd_color (pal_color)
    );

    // Stage 1: decoded pixel, palette read in flight
    always_comb
    begin
        priority if (take)
            s1_valid_next = info.valid;
        else if (out_load)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_info_reg <= info;
        end
        if (out_load)
        begin
            pixel_reg     <= s1_info_reg.palette ? {8'd0, pal_color} : s1_info_reg.pixel;
            row_end_reg   <= s1_info_reg.row_end;
            frame_end_reg <= s1_info_reg.frame_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_word = pixel_reg;
    assign row_end    = row_end_reg;
    assign frame_end  = frame_end_reg;

    // Frame end is only ever flagged on a row end
    a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!frame_end || row_end))
        else $error("frame_end without row_end");

    // A palette write never produces a pixel
    a_pal_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (command == bru_pkg::CMD_PALETTE)) |=> !s1_valid_reg)
        else $error("palette write produced a pixel");

    // Stage 1 holds its word while the output is stalled
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=>
            (s1_valid_reg && $stable(s1_info_reg)))
        else $error("stage 1 word lost under stall");

endmodule

// ===== hw/rtl/bru_palette.sv =====
// Palette memory with per-entry valid bits and a registered read port.
module bru_palette #(
    parameter int DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [7:0]  wr_index,
    input  logic [23:0] wr_color,
    input  logic        rd_en,
    input  logic [7:0]  rd_index,
    output logic [23:0] rd_color
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [23:0]      mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [23:0]      rd_data_reg;
    logic             rd_ok_reg;
    logic             wr_in_range;
    logic             rd_in_range;

    // Indexes at or above the depth are dropped on write and read as zero
    assign wr_in_range = {1'b0, wr_index} < 9'(DEPTH);
    assign rd_in_range = {1'b0, rd_index} < 9'(DEPTH);

    // Storage array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_index[AW-1:0]] <= wr_color;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_index[AW-1:0]];
        end
    end

    // Valid bits stand in for clearing the array at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_in_range)
            begin
                vld_reg[wr_index[AW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= rd_in_range && vld_reg[rd_index[AW-1:0]];
            end
        end
    end

    assign rd_color = rd_ok_reg ? rd_data_reg : 24'd0;

endmodule

// ===== hw/rtl/bru_unpack.sv =====
// Configuration registers, byte assembly, padding skip and row/frame counters.
module bru_unpack #(
    parameter int MAX_ROW_PIXELS = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                command,
    input  logic [7:0]          source_byte,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    output bru_pkg::pix_info_t  info
);

    localparam int CW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;

    logic [1:0]    fmt_reg;
    logic [12:0]   row_width_reg;
    logic [12:0]   row_count_reg;
    logic [1:0]    byte_pos_reg;
    logic [23:0]   partial_reg;
    logic [CW-1:0] col_reg;
    logic [1:0]    pad_reg;
    logic [11:0]   row_reg;

    logic          is_data;
    logic          in_pad;
    logic          assemble;
    logic          emit;
    logic          cfg_hit;
    logic [12:0]   width_eff;
    logic [12:0]   rows_eff;
    logic [2:0]    bpp;
    logic [4:0]    row_bytes_lo;
    logic [1:0]    pad_fill;
    logic          row_last;
    logic          frame_last;
    logic [15:0]   word16;
    logic [31:0]   pixel;

    // Control decode
    assign is_data  = (command == bru_pkg::CMD_DATA);
    assign in_pad   = (pad_reg != 2'd0);
    assign assemble = (byte_pos_reg < fmt_reg);
    assign emit     = is_data && !in_pad && !assemble;
    assign cfg_hit  = cfg_write && ((cfg_index == bru_pkg::REG_FORMAT) ||
                                    (cfg_index == bru_pkg::REG_ROW_WIDTH) ||
                                    (cfg_index == bru_pkg::REG_ROW_COUNT));

    // Effective width and row count: zero acts as one, oversize is clamped
    always_comb
    begin
        if (row_width_reg == 13'd0)
            width_eff = 13'd1;
        else if ({4'd0, row_width_reg} > 17'(MAX_ROW_PIXELS))
            width_eff = 13'(MAX_ROW_PIXELS);
        else
            width_eff = row_width_reg;

        if (row_count_reg == 13'd0)
            rows_eff = 13'd1;
        else if (row_count_reg > bru_pkg::MAX_ROWS)
            rows_eff = bru_pkg::MAX_ROWS;
        else
            rows_eff = row_count_reg;
    end

    // Row padding: bytes needed to bring width * bpp to a multiple of four
    assign bpp          = {1'b0, fmt_reg} + 3'd1;
    assign row_bytes_lo = {3'd0, width_eff[1:0]} * {2'd0, bpp};
    assign pad_fill     = 2'd0 - row_bytes_lo[1:0];

    // End of row / frame
    assign row_last   = (17'(col_reg) + 17'd1) >= {4'd0, width_eff};
    assign frame_last = ({1'b0, row_reg} + 13'd1) >= rows_eff;

    // Pixel formatting from held bytes and the final byte
    assign word16 = {source_byte, partial_reg[7:0]};
    always_comb
    begin
        unique case (fmt_reg)
            bru_pkg::FMT_PAL8:   pixel = 32'd0;
            bru_pkg::FMT_RGB555: pixel = {8'd0,
                                          3'd0, 5'((word16 & bru_pkg::MASK_RED) >> 10),
                                          3'd0, 5'((word16 & bru_pkg::MASK_GREEN) >> 5),
                                          3'd0, 5'(word16 & bru_pkg::MASK_BLUE)};
            bru_pkg::FMT_BGR24:  pixel = {8'd0, source_byte, partial_reg[15:0]};
            bru_pkg::FMT_ARGB32: pixel = {source_byte, partial_reg};
            default:             pixel = 32'd0;
        endcase
    end

    assign info.valid     = emit;
    assign info.palette   = (fmt_reg == bru_pkg::FMT_PAL8);
    assign info.pixel     = pixel;
    assign info.row_end   = row_last;
    assign info.frame_end = row_last && frame_last;

    // Registers and stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= bru_pkg::FMT_ARGB32;
            row_width_reg <= 13'd1;
            row_count_reg <= 13'd1;
            byte_pos_reg  <= 2'd0;
            partial_reg   <= 24'd0;
            col_reg       <= '0;
            pad_reg       <= 2'd0;
            row_reg       <= 12'd0;
        end
        else if (cfg_hit)
        begin
            // Any register write restarts the frame; palette is kept
            unique case (cfg_index)
                bru_pkg::REG_FORMAT:    fmt_reg       <= cfg_data[1:0];
                bru_pkg::REG_ROW_WIDTH: row_width_reg <= cfg_data;
                default:                row_count_reg <= cfg_data;
            endcase
            byte_pos_reg <= 2'd0;
            partial_reg  <= 24'd0;
            col_reg      <= '0;
            pad_reg      <= 2'd0;
            row_reg      <= 12'd0;
        end
        else if (take && is_data)
        begin
            priority if (in_pad)
            begin
                pad_reg <= pad_reg - 2'd1;
            end
            else if (assemble)
            begin
                unique case (byte_pos_reg)
                    2'd0:    partial_reg[7:0]   <= source_byte;
                    2'd1:    partial_reg[15:8]  <= source_byte;
                    default: partial_reg[23:16] <= source_byte;
                endcase
                byte_pos_reg <= byte_pos_reg + 2'd1;
            end
            else
            begin
                byte_pos_reg <= 2'd0;
                partial_reg  <= 24'd0;
                if (row_last)
                begin
                    col_reg <= '0;
                    pad_reg <= pad_fill;
                    row_reg <= frame_last ? 12'd0 : row_reg + 12'd1;
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench for the bitmap row unpacker: random byte streams, scoreboard check of pixel words.
`timescale 1ns / 100ps

module tb;

    localparam int         ROW_PIXELS_MAX  = 4096;
    localparam logic [1:0] REG_NONE        = 2'd3;   // index past the register list
    localparam int         RANDOM_WORDS    = 1350;
    localparam int         CLAMP_WORDS     = 300;
    localparam int         IDLE_LIMIT      = 2000;
    localparam int         PRESSURE_CYCLES = 200;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [31:0] pixel;
        logic        row_end;
        logic        frame_end;
    } pixel_result_t;

    // Scoreboard: tracks unpacker state and queues the pixel words it should produce
    class pixel_scoreboard;
        logic [1:0]    fmt;
        logic [12:0]   width_reg;
        logic [12:0]   rows_reg;
        logic [23:0]   palette [256];
        int unsigned   byte_pos;
        int unsigned   column;
        int unsigned   padding;
        int unsigned   row;
        logic [23:0]   partial;
        pixel_result_t expected_pixels [$];
        int unsigned   mismatches;

        function new();
            foreach (palette[i])
                palette[i] = '0;
            fmt        = bru_pkg::FMT_ARGB32;
            width_reg  = 13'd1;
            rows_reg   = 13'd1;
            mismatches = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            byte_pos = 0;
            partial  = '0;
            column   = 0;
            padding  = 0;
            row      = 0;
        endfunction

        // zero acts as one, anything above the top acts as the top
        function int unsigned clamp_count(logic [12:0] v, int unsigned top);
            if (v == 0)
                return 1;
            if (v > top)
                return top;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [12:0] val);
            case (idx)
                bru_pkg::REG_FORMAT:    fmt       = val[1:0];
                bru_pkg::REG_ROW_WIDTH: width_reg = val;
                bru_pkg::REG_ROW_COUNT: rows_reg  = val;
                default:                return;
            endcase
            clear_stream();
        endfunction

        function void note_word(logic cmd, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b, logic [7:0] src);
            int unsigned   depth;
            int unsigned   eff_w;
            int unsigned   eff_rows;
            logic [15:0]   w;
            logic [31:0]   pix;
            pixel_result_t res;

            if (cmd == bru_pkg::CMD_PALETTE) begin
                palette[idx] = {r, g, b};
                return;
            end
            // padding bytes are swallowed
            if (padding != 0) begin
                padding--;
                return;
            end
            depth = int'(fmt) + 1;
            if (byte_pos + 1 < depth) begin
                partial[8*byte_pos +: 8] = src;
                byte_pos++;
                return;
            end

            case (fmt)
                bru_pkg::FMT_PAL8:   pix = {8'h00, palette[src]};
                bru_pkg::FMT_RGB555: begin
                    w   = {src, partial[7:0]};
                    pix = {8'h00, 3'd0, 5'((w & bru_pkg::MASK_RED) >> 10), 3'd0,
                           5'((w & bru_pkg::MASK_GREEN) >> 5), 3'd0,
                           5'(w & bru_pkg::MASK_BLUE)};
                end
                bru_pkg::FMT_BGR24:  pix = {8'h00, src, partial[15:0]};
                default:             pix = {src, partial};
            endcase
            byte_pos = 0;
            partial  = '0;

            eff_w         = clamp_count(width_reg, ROW_PIXELS_MAX);
            eff_rows      = clamp_count(rows_reg, bru_pkg::MAX_ROWS);
            res.pixel     = pix;
            res.row_end   = (column + 1 >= eff_w);
            res.frame_end = 1'b0;
            if (res.row_end) begin
                column  = 0;
                padding = (4 - (eff_w * depth) % 4) % 4;
                if (row + 1 >= eff_rows) begin
                    res.frame_end = 1'b1;
                    row           = 0;
                end else begin
                    row++;
                end
            end else begin
                column++;
            end
            expected_pixels.push_back(res);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h",
                         $time, field, want, got);
        endfunction

        function void check_pixel(logic [31:0] pix, logic re, logic fe);
            pixel_result_t want;

            if (expected_pixels.size() == 0) begin
                report("unexpected pixel word", 32'h0, pix);
                return;
            end
            want = expected_pixels.pop_front();
            if (pix !== want.pixel)
                report("pixel_word", want.pixel, pix);
            if (re !== want.row_end)
                report("row_end", 32'(want.row_end), 32'(re));
            if (fe !== want.frame_end)
                report("frame_end", 32'(want.frame_end), 32'(fe));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [7:0]  palette_index;
    logic [7:0]  palette_red;
    logic [7:0]  palette_green;
    logic [7:0]  palette_blue;
    logic [7:0]  source_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] pixel_word;
    logic        row_end;
    logic        frame_end;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    pixel_scoreboard sb;
    int unsigned     sent_words;
    int unsigned     random_stop;
    int unsigned     idle_cycles;
    bit              hold_off_request;
    bit              steady_sender;

    bitmap_row_to_argb32_unpacker_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .palette_index (palette_index),
        .palette_red   (palette_red),
        .palette_green (palette_green),
        .palette_blue  (palette_blue),
        .source_byte   (source_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_word    (pixel_word),
        .row_end       (row_end),
        .frame_end     (frame_end),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 80)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 10);
        return $urandom_range(11, 40);
    endfunction

    // Monitor: score accepted words on both sides, watchdog on stalls
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_word(command, palette_index, palette_red, palette_green,
                             palette_blue, source_byte);
            if (out_valid && out_ready)
                sb.check_pixel(pixel_word, row_end, frame_end);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[bitmap_row_to_argb32_unpacker_unit] ERROR");
                $finish;
            end
        end
    end

    // Receiver: random ready, with a long hold-off on request
    initial begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            stall = gap_length();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic send_word(logic cmd, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [7:0] src);
        int gap;
        command       <= cmd;
        palette_index <= idx;
        palette_red   <= r;
        palette_green <= g;
        palette_blue  <= b;
        source_byte   <= src;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sent_words++;
        gap = steady_sender ? 0 : gap_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // palette fields carry junk on data words, source_byte on palette words
    task automatic send_data(logic [7:0] src);
        send_word(bru_pkg::CMD_DATA, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), src);
    endtask

    task automatic send_palette(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        send_word(bru_pkg::CMD_PALETTE, idx, r, g, b, 8'($urandom));
    endtask

    // Stop offering, wait for every pending pixel, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [12:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // One configuration, then whole frames of rows (three rows stand in for more than four), sometimes cut short
    task automatic random_phase();
        logic [1:0]  fmt;
        logic [12:0] w;
        logic [12:0] rows;
        int unsigned depth;
        int unsigned eff_w;
        int unsigned rows_gen;
        int unsigned pad;
        int unsigned budget;
        int unsigned n;

        fmt = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 19))
            0:       w = 13'd0;
            1, 2:    w = 13'($urandom_range(13, 64));
            default: w = 13'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 19))
            0:       rows = 13'd0;
            1:       rows = 13'($urandom_range(4096, 8191));
            default: rows = 13'($urandom_range(1, 4));
        endcase
        set_reg(bru_pkg::REG_FORMAT, 13'(fmt));
        if ($urandom_range(0, 4) != 0)
            set_reg(bru_pkg::REG_ROW_WIDTH, w);
        if ($urandom_range(0, 4) != 0)
            set_reg(bru_pkg::REG_ROW_COUNT, rows);
        if ($urandom_range(0, 9) == 0)
            set_reg(REG_NONE, 13'($urandom));

        depth    = int'(sb.fmt) + 1;
        eff_w    = sb.clamp_count(sb.width_reg, ROW_PIXELS_MAX);
        rows_gen = sb.clamp_count(sb.rows_reg, bru_pkg::MAX_ROWS);
        if (rows_gen > 4)
            rows_gen = 3;
        pad      = (4 - (eff_w * depth) % 4) % 4;
        budget   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 32'hFFFF_FFFF;
        steady_sender = ($urandom_range(0, 3) == 0);

        if (fmt == bru_pkg::FMT_PAL8)
            repeat ($urandom_range(2, 10))
                send_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

        n = 0;
        repeat ($urandom_range(1, 3)) begin
            repeat (rows_gen) begin
                repeat (eff_w * depth + pad) begin
                    if (n >= budget || sent_words >= random_stop)
                        return;
                    send_data(8'($urandom));
                    n++;
                    // stray palette write in the middle of the stream
                    if ($urandom_range(0, 39) == 0)
                        send_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    // Main sequence
    initial begin
        bit mid_hold_done;
        int unsigned first_word;

        sb               = new();
        sent_words       = 0;
        random_stop      = 0;
        idle_cycles      = 0;
        hold_off_request = 1'b0;
        steady_sender    = 1'b0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        command          = bru_pkg::CMD_DATA;
        palette_index    = '0;
        palette_red      = '0;
        palette_green    = '0;
        palette_blue     = '0;
        source_byte      = '0;
        cfg_write        = 1'b0;
        cfg_index        = bru_pkg::REG_FORMAT;
        cfg_data         = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: 32 bpp, one pixel per row and frame
        repeat (4) send_data(8'hFF);
        repeat (4) send_data(8'h00);

        // palette: unwritten entry reads zero, extremes, write during padding
        settle();
        set_reg(bru_pkg::REG_FORMAT, 13'(bru_pkg::FMT_PAL8));
        set_reg(bru_pkg::REG_ROW_WIDTH, 13'd3);
        set_reg(bru_pkg::REG_ROW_COUNT, 13'd2);
        send_data(8'h80);
        send_palette(8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_palette(8'hFF, 8'h01, 8'h80, 8'hFE);
        send_data(8'h00);
        send_data(8'hFF);
        send_palette(8'h80, 8'hAA, 8'h55, 8'h00);
        send_data(8'h33);
        send_data(8'h80);
        send_data(8'hFF);
        send_data(8'h00);
        send_data(8'hCC);

        // 5-5-5 with bit 15 set and alone
        settle();
        set_reg(bru_pkg::REG_FORMAT, 13'(bru_pkg::FMT_RGB555));
        set_reg(bru_pkg::REG_ROW_WIDTH, 13'd1);
        send_data(8'hFF);
        send_data(8'hFF);
        send_data(8'h11);
        send_data(8'h22);
        send_data(8'h00);
        send_data(8'h80);

        // 24 bpp, zero width and count; a write past the list keeps the partial pixel
        settle();
        set_reg(bru_pkg::REG_FORMAT, 13'(bru_pkg::FMT_BGR24));
        set_reg(bru_pkg::REG_ROW_WIDTH, 13'd0);
        set_reg(bru_pkg::REG_ROW_COUNT, 13'd0);
        send_data(8'h01);
        send_data(8'h02);
        settle();
        set_reg(REG_NONE, 13'h1FFF);
        send_data(8'h03);
        send_data(8'h44);

        // oversized width and count clamp to the maximum; long receiver hold-off here
        settle();
        set_reg(bru_pkg::REG_FORMAT, 13'(bru_pkg::FMT_PAL8));
        set_reg(bru_pkg::REG_ROW_WIDTH, 13'h1FFF);
        set_reg(bru_pkg::REG_ROW_COUNT, 13'h1FFF);
        hold_off_request = 1'b1;
        repeat (CLAMP_WORDS) send_data(8'($urandom));

        // random phases
        first_word    = sent_words;
        random_stop   = first_word + RANDOM_WORDS;
        mid_hold_done = 1'b0;
        while (sent_words - first_word < RANDOM_WORDS) begin
            if (!mid_hold_done && sent_words - first_word > RANDOM_WORDS / 2) begin
                hold_off_request = 1'b1;
                mid_hold_done    = 1'b1;
            end
            settle();
            random_phase();
        end
        steady_sender = 1'b0;

        settle();
        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
            $display("[bitmap_row_to_argb32_unpacker_unit] OK");
        else
            $display("[bitmap_row_to_argb32_unpacker_unit] ERROR");
        $finish;
    end

endmodule
